FILE: src/fkin_pkg.sv
// Shared types, constants and helper functions for the serial chain
// forward kinematics unit. No dependencies; every file but the checker uses it.
package fkin_pkg;

  localparam int MAX_LINKS_DEF = 64;
  localparam int IN_TDATA_W    = 264;
  localparam int OUT_TDATA_W   = 136;
  localparam int CORDIC_STEPS  = 31;

  localparam logic signed [31:0] ONE_Q30      = 32'sd1073741824;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [33:0] ONE_OP_Q30   = 34'sd1073741824;
  localparam logic signed [33:0] ONE_OP_Q31   = 34'sd2147483648;

  typedef enum logic [1:0] {
    MOP_REL   = 2'd0,
    MOP_MAT   = 2'd1,
    MOP_CPREV = 2'd2,
    MOP_COWN  = 2'd3
  } mul_op_t;

  typedef enum logic [2:0] {
    RS_CPREV = 3'd0,
    RS_ROW0  = 3'd1,
    RS_ROW1  = 3'd2,
    RS_ROW2  = 3'd3,
    RS_COWN  = 3'd4
  } res_sel_t;

  typedef struct packed {
    logic       load;
    logic       cordic_step;
    logic [4:0] cordic_idx;
    logic       mul_vld;
    mul_op_t    mul_op;
    logic [3:0] mul_e;
    logic [1:0] mul_k;
    logic       mul_first;
    logic       mul_last;
    logic       emit_ld;
    res_sel_t   emit_sel;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic have_prev;
    logic last;
    logic out_busy;
    logic out_fire;
  } sts_t;

  // Arctangent of 2^-i as a binary angle.
  function automatic logic [29:0] cordic_atan(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // Relative-transform entry written by the n-th single product.
  function automatic logic [3:0] rel_target(input logic [2:0] n);
    logic [3:0] e;
    unique case (n)
      3'd0: e = 4'd4;
      3'd1: e = 4'd5;
      3'd2: e = 4'd7;
      3'd3: e = 4'd8;
      3'd4: e = 4'd9;
      default: e = 4'd11;
    endcase
    return e;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: src/serial_chain_forward_kinematics_unit.sv
// Serial chain forward kinematics unit (modified DH links), top level.
// A base row word is written to the base pose from the idle state. A link word runs
// 31 CORDIC steps, then 57 products through the one shared multiplier and its two
// pipeline stages, then one result word (3 to 5) per cycle while the output is not
// stalled, then a commit. Synchronous active-low reset restores the identity base pose.
module serial_chain_forward_kinematics_unit #(
  parameter int MAX_LINKS = fkin_pkg::MAX_LINKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // base_row, base_r0, base_r1, base_r2, base_t, link_alpha, link_a, link_d,
  // link_theta, zero fill
  input  logic [fkin_pkg::IN_TDATA_W-1:0]  in_tdata,
  // operation
  input  logic                             in_tuser,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // link_index, row_index, m0, m1, m2, m3
  output logic [fkin_pkg::OUT_TDATA_W-1:0] out_tdata,
  // kind
  output logic                             out_tuser,
  output logic                             out_tlast
);

  fkin_pkg::cmd_t cmd;
  fkin_pkg::sts_t sts;

  fkin_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  fkin_datapath #(
    .MAX_LINKS (MAX_LINKS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: src/fkin_cordic.sv
// Iterative rotation-mode CORDIC for sine and cosine of a binary angle.
// One micro-rotation per step command. Depends on fkin_pkg.
module fkin_cordic (
  input  logic                clk,
  input  logic                init,
  input  logic [31:0]         angle,
  input  logic                step,
  input  logic [4:0]          idx,
  output logic signed [33:0]  cos_o,
  output logic signed [33:0]  sin_o
);

  logic signed [33:0] x_r, y_r, z_r;
  logic               flip_r;
  logic [31:0]        u;
  logic               flip;
  logic signed [33:0] dx, dy, at;

  // Angles in the left half plane are turned by pi; the result is negated.
  assign flip = (angle > 32'h40000000) && (angle < 32'hC0000000);
  assign u    = flip ? angle + 32'h80000000 : angle;
  assign dx   = y_r >>> idx;
  assign dy   = x_r >>> idx;
  assign at   = $signed({4'd0, fkin_pkg::cordic_atan(idx)});

  always_ff @(posedge clk) begin
    if (init) begin
      x_r    <= fkin_pkg::CORDIC_START;
      y_r    <= '0;
      z_r    <= {{2{u[31]}}, u};
      flip_r <= flip;
    end else if (step) begin
      if (!z_r[33]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
  end

  assign cos_o = flip_r ? -x_r : x_r;
  assign sin_o = flip_r ? -y_r : y_r;

endmodule

FILE: src/fkin_datapath.sv
// Datapath: pose storage, two CORDIC units, one shared multiplier with a
// rounding accumulator, and the output word register. Depends on fkin_pkg.
module fkin_datapath #(
  parameter int MAX_LINKS = fkin_pkg::MAX_LINKS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fkin_pkg::cmd_t                     cmd,
  output fkin_pkg::sts_t                     sts,
  input  logic [fkin_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               in_tuser,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [fkin_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tuser,
  output logic                               out_tlast
);

  localparam int CW = $clog2(MAX_LINKS + 1);

  logic signed [31:0] base_r [12];
  logic signed [31:0] run_r  [12];
  logic signed [31:0] nf_r   [12];
  logic signed [31:0] prevf_r [6];
  logic signed [31:0] cprev_r [3];
  logic signed [31:0] cown_r  [3];
  logic signed [33:0] rel_r   [6];
  logic [CW-1:0]      cnt_r;
  logic               have_prev_r;
  logic               last_r;
  logic signed [31:0] a_r, d_r;

  logic signed [67:0] prod_r;
  fkin_pkg::mul_op_t  p_op_r;
  logic [3:0]         p_e_r;
  logic               p_vld_r, p_first_r, p_last_r;
  logic signed [39:0] acc_r;

  logic               out_vld_r;
  logic [5:0]         o_idx_r;
  logic [1:0]         o_row_r;
  logic signed [31:0] o_m0_r, o_m1_r, o_m2_r, o_m3_r;
  logic               o_kind_r, o_end_r;

  logic signed [33:0] ca, sa, ct, st;
  logic signed [33:0] op_a, op_b, rel_b;
  logic signed [67:0] r30, r31;
  logic signed [39:0] rnd, acc_nxt;
  logic [1:0]         row_in;
  logic [1:0]         r, c, j;
  logic               out_fire;

  fkin_cordic u_cordic_alpha (
    .clk   (clk),
    .init  (cmd.load),
    .angle (in_tdata[161:130]),
    .step  (cmd.cordic_step),
    .idx   (cmd.cordic_idx),
    .cos_o (ca),
    .sin_o (sa)
  );

  fkin_cordic u_cordic_theta (
    .clk   (clk),
    .init  (cmd.load),
    .angle (in_tdata[257:226]),
    .step  (cmd.cordic_step),
    .idx   (cmd.cordic_idx),
    .cos_o (ct),
    .sin_o (st)
  );

  function automatic logic [5:0] link_idx(input logic [CW-1:0] v);
    logic [5:0] o;
    if (v > CW'(MAX_LINKS - 1)) begin
      o = 6'(MAX_LINKS - 1);
    end else begin
      o = 6'(v);
    end
    return o;
  endfunction

  assign row_in   = in_tdata[1:0];
  assign r        = cmd.mul_e[3:2];
  assign c        = cmd.mul_e[1:0];
  assign j        = cmd.mul_e[1:0];
  assign out_fire = out_vld_r && out_tready;

  // Entry of the relative transform in row k, column c.
  always_comb begin
    unique case ({cmd.mul_k, c})
      4'd0:    rel_b = ct;
      4'd1:    rel_b = -st;
      4'd3:    rel_b = {{2{a_r[31]}}, a_r};
      4'd4:    rel_b = rel_r[0];
      4'd5:    rel_b = rel_r[1];
      4'd6:    rel_b = -sa;
      4'd7:    rel_b = rel_r[2];
      4'd8:    rel_b = rel_r[3];
      4'd9:    rel_b = rel_r[4];
      4'd10:   rel_b = ca;
      4'd11:   rel_b = rel_r[5];
      default: rel_b = '0;
    endcase
  end

  // Operand selection. A translation is folded in as a product with one,
  // so every array is read at a single address per cycle.
  always_comb begin
    unique case (cmd.mul_op)
      fkin_pkg::MOP_REL: begin
        unique case (cmd.mul_e)
          4'd4:    begin op_a = ca;  op_b = st; end
          4'd5:    begin op_a = ca;  op_b = ct; end
          4'd7:    begin op_a = -sa; op_b = {{2{d_r[31]}}, d_r}; end
          4'd8:    begin op_a = sa;  op_b = st; end
          4'd9:    begin op_a = sa;  op_b = ct; end
          default: begin op_a = ca;  op_b = {{2{d_r[31]}}, d_r}; end
        endcase
      end
      fkin_pkg::MOP_MAT: begin
        op_a = {{2{run_r[{r, cmd.mul_k}][31]}}, run_r[{r, cmd.mul_k}]};
        op_b = (cmd.mul_k == 2'd3) ? fkin_pkg::ONE_OP_Q30 : rel_b;
      end
      fkin_pkg::MOP_CPREV: begin
        op_a = {{2{prevf_r[cmd.mul_k[0] ? 3'({1'b0, j}) + 3'd3 : 3'({1'b0, j})][31]}},
                prevf_r[cmd.mul_k[0] ? 3'({1'b0, j}) + 3'd3 : 3'({1'b0, j})]};
        op_b = cmd.mul_k[0] ? fkin_pkg::ONE_OP_Q31 : {{2{a_r[31]}}, a_r};
      end
      default: begin
        op_a = {{2{nf_r[{j, cmd.mul_k[0] ? 2'd3 : 2'd0}][31]}},
                nf_r[{j, cmd.mul_k[0] ? 2'd3 : 2'd0}]};
        op_b = cmd.mul_k[0] ? fkin_pkg::ONE_OP_Q31 : {{2{a_r[31]}}, a_r};
      end
    endcase
  end

  // Centroid products round at bit 31, all others at bit 30.
  assign r30     = (prod_r + 68'sd536870912) >>> 30;
  assign r31     = (prod_r + 68'sd1073741824) >>> 31;
  assign rnd     = (p_op_r == fkin_pkg::MOP_CPREV || p_op_r == fkin_pkg::MOP_COWN) ?
                   r31[39:0] : r30[39:0];
  assign acc_nxt = p_first_r ? rnd : acc_r + rnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 12; i++) begin
        base_r[i] <= (i == 0 || i == 5 || i == 10) ? fkin_pkg::ONE_Q30 : '0;
        run_r[i]  <= (i == 0 || i == 5 || i == 10) ? fkin_pkg::ONE_Q30 : '0;
      end
      for (int i = 0; i < 6; i++) begin
        prevf_r[i] <= '0;
      end
      cnt_r       <= '0;
      have_prev_r <= 1'b0;
      p_vld_r     <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (!in_tuser) begin
          if (row_in != 2'd3) begin
            base_r[{row_in, 2'd0}] <= $signed(in_tdata[33:2]);
            base_r[{row_in, 2'd1}] <= $signed(in_tdata[65:34]);
            base_r[{row_in, 2'd2}] <= $signed(in_tdata[97:66]);
            base_r[{row_in, 2'd3}] <= $signed(in_tdata[129:98]);
          end
        end else if (!have_prev_r) begin
          // First link of a chain starts from the base pose.
          for (int i = 0; i < 12; i++) begin
            run_r[i] <= base_r[i];
          end
          cnt_r <= '0;
        end
      end

      p_vld_r <= cmd.mul_vld;

      if (cmd.emit_ld) begin
        out_vld_r <= 1'b1;
      end else if (out_fire) begin
        out_vld_r <= 1'b0;
      end

      if (cmd.commit) begin
        for (int i = 0; i < 12; i++) begin
          run_r[i] <= nf_r[i];
        end
        for (int i = 0; i < 3; i++) begin
          prevf_r[i]     <= nf_r[i * 4];
          prevf_r[3 + i] <= nf_r[i * 4 + 3];
        end
        if (last_r) begin
          cnt_r       <= '0;
          have_prev_r <= 1'b0;
        end else begin
          if (cnt_r < CW'(MAX_LINKS)) begin
            cnt_r <= CW'(cnt_r + 1'b1);
          end
          have_prev_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_tuser) begin
      a_r    <= $signed(in_tdata[193:162]);
      d_r    <= $signed(in_tdata[225:194]);
      last_r <= in_tlast;
    end

    prod_r    <= op_a * op_b;
    p_op_r    <= cmd.mul_op;
    p_e_r     <= cmd.mul_e;
    p_first_r <= cmd.mul_first;
    p_last_r  <= cmd.mul_last;

    if (p_vld_r) begin
      acc_r <= acc_nxt;
      if (p_last_r) begin
        unique case (p_op_r)
          fkin_pkg::MOP_REL: begin
            unique case (p_e_r)
              4'd4:    rel_r[0] <= acc_nxt[33:0];
              4'd5:    rel_r[1] <= acc_nxt[33:0];
              4'd7:    rel_r[2] <= acc_nxt[33:0];
              4'd8:    rel_r[3] <= acc_nxt[33:0];
              4'd9:    rel_r[4] <= acc_nxt[33:0];
              default: rel_r[5] <= acc_nxt[33:0];
            endcase
          end
          fkin_pkg::MOP_MAT:   nf_r[p_e_r] <= fkin_pkg::sat32(acc_nxt);
          fkin_pkg::MOP_CPREV: cprev_r[p_e_r[1:0]] <= fkin_pkg::sat32(acc_nxt);
          default:             cown_r[p_e_r[1:0]] <= fkin_pkg::sat32(acc_nxt);
        endcase
      end
    end

    if (cmd.emit_ld) begin
      unique case (cmd.emit_sel)
        fkin_pkg::RS_CPREV: begin
          o_kind_r <= 1'b1; o_idx_r <= link_idx(CW'(cnt_r - 1'b1)); o_row_r <= 2'd0;
          o_m0_r <= cprev_r[0]; o_m1_r <= cprev_r[1]; o_m2_r <= cprev_r[2];
          o_m3_r <= '0; o_end_r <= 1'b0;
        end
        fkin_pkg::RS_ROW0: begin
          o_kind_r <= 1'b0; o_idx_r <= link_idx(cnt_r); o_row_r <= 2'd0;
          o_m0_r <= nf_r[0]; o_m1_r <= nf_r[1]; o_m2_r <= nf_r[2];
          o_m3_r <= nf_r[3]; o_end_r <= 1'b0;
        end
        fkin_pkg::RS_ROW1: begin
          o_kind_r <= 1'b0; o_idx_r <= link_idx(cnt_r); o_row_r <= 2'd1;
          o_m0_r <= nf_r[4]; o_m1_r <= nf_r[5]; o_m2_r <= nf_r[6];
          o_m3_r <= nf_r[7]; o_end_r <= 1'b0;
        end
        fkin_pkg::RS_ROW2: begin
          o_kind_r <= 1'b0; o_idx_r <= link_idx(cnt_r); o_row_r <= 2'd2;
          o_m0_r <= nf_r[8]; o_m1_r <= nf_r[9]; o_m2_r <= nf_r[10];
          o_m3_r <= nf_r[11]; o_end_r <= 1'b0;
        end
        default: begin
          o_kind_r <= 1'b1; o_idx_r <= link_idx(cnt_r); o_row_r <= 2'd0;
          o_m0_r <= cown_r[0]; o_m1_r <= cown_r[1]; o_m2_r <= cown_r[2];
          o_m3_r <= '0; o_end_r <= 1'b1;
        end
      endcase
    end
  end

  assign sts.have_prev = have_prev_r;
  assign sts.last      = last_r;
  assign sts.out_busy  = out_vld_r;
  assign sts.out_fire  = out_fire;

  assign out_tvalid = out_vld_r;
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_end_r;
  assign out_tdata  = {o_m3_r, o_m2_r, o_m1_r, o_m0_r, o_row_r, o_idx_r};

endmodule

FILE: src/fkin_ctrl.sv
// Controller: sequences CORDIC steps, multiplier products and result words
// for one input word at a time. Depends on fkin_pkg.
module fkin_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic           in_tuser,
  input  fkin_pkg::sts_t sts,
  output fkin_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CORD   = 8'b0000_0010,
    S_REL    = 8'b0000_0100,
    S_MAT    = 8'b0000_1000,
    S_CPREV  = 8'b0001_0000,
    S_COWN   = 8'b0010_0000,
    S_EMIT   = 8'b0100_0000,
    S_COMMIT = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic [3:0]          e_r, e_nxt;
  logic [1:0]          k_r, k_nxt;
  fkin_pkg::res_sel_t  sel_r, sel_nxt;
  logic                mat_last;

  assign in_tready = (state_r == S_IDLE);
  // The translation column takes a fourth product.
  assign mat_last  = (e_r[1:0] == 2'd3) ? (k_r == 2'd3) : (k_r == 2'd2);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    e_nxt     = e_r;
    k_nxt     = k_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_tuser) begin
            state_nxt = S_CORD;
            cnt_nxt   = '0;
          end
        end
      end
      S_CORD: begin
        cmd.cordic_step = 1'b1;
        cmd.cordic_idx  = cnt_r;
        if (cnt_r == 5'(fkin_pkg::CORDIC_STEPS - 1)) begin
          state_nxt = S_REL;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_REL: begin
        // The idle tail of this state lets the last product reach its register.
        if (cnt_r < 5'd6) begin
          cmd.mul_vld   = 1'b1;
          cmd.mul_op    = fkin_pkg::MOP_REL;
          cmd.mul_e     = fkin_pkg::rel_target(cnt_r[2:0]);
          cmd.mul_first = 1'b1;
          cmd.mul_last  = 1'b1;
        end
        if (cnt_r == 5'd7) begin
          state_nxt = S_MAT;
          e_nxt     = '0;
          k_nxt     = '0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_MAT: begin
        cmd.mul_vld   = 1'b1;
        cmd.mul_op    = fkin_pkg::MOP_MAT;
        cmd.mul_e     = e_r;
        cmd.mul_k     = k_r;
        cmd.mul_first = (k_r == 2'd0);
        cmd.mul_last  = mat_last;
        if (mat_last) begin
          k_nxt = '0;
          if (e_r == 4'd11) begin
            state_nxt = S_CPREV;
            cnt_nxt   = '0;
          end else begin
            e_nxt = e_r + 4'd1;
          end
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      S_CPREV: begin
        cmd.mul_vld   = 1'b1;
        cmd.mul_op    = fkin_pkg::MOP_CPREV;
        cmd.mul_e     = {2'd0, cnt_r[2:1]};
        cmd.mul_k     = {1'b0, cnt_r[0]};
        cmd.mul_first = !cnt_r[0];
        cmd.mul_last  = cnt_r[0];
        if (cnt_r == 5'd5) begin
          state_nxt = S_COWN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_COWN: begin
        if (cnt_r < 5'd6) begin
          cmd.mul_vld   = 1'b1;
          cmd.mul_op    = fkin_pkg::MOP_COWN;
          cmd.mul_e     = {2'd0, cnt_r[2:1]};
          cmd.mul_k     = {1'b0, cnt_r[0]};
          cmd.mul_first = !cnt_r[0];
          cmd.mul_last  = cnt_r[0];
        end
        if (cnt_r == 5'd7) begin
          state_nxt = S_EMIT;
          sel_nxt   = sts.have_prev ? fkin_pkg::RS_CPREV : fkin_pkg::RS_ROW0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_EMIT: begin
        if (!sts.out_busy || sts.out_fire) begin
          cmd.emit_ld  = 1'b1;
          cmd.emit_sel = sel_r;
          unique case (sel_r)
            fkin_pkg::RS_CPREV: sel_nxt = fkin_pkg::RS_ROW0;
            fkin_pkg::RS_ROW0:  sel_nxt = fkin_pkg::RS_ROW1;
            fkin_pkg::RS_ROW1:  sel_nxt = fkin_pkg::RS_ROW2;
            fkin_pkg::RS_ROW2: begin
              if (sts.last) begin
                sel_nxt = fkin_pkg::RS_COWN;
              end else begin
                state_nxt = S_COMMIT;
              end
            end
            default: state_nxt = S_COMMIT;
          endcase
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      e_r     <= '0;
      k_r     <= '0;
      sel_r   <= fkin_pkg::RS_ROW0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      e_r     <= e_nxt;
      k_r     <= k_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule

FILE: test/fkin_checker.sv
// Checker for the serial chain forward kinematics unit: watches both stream
// channels, predicts every result word from accepted input words, compares.
// Depends on nothing but the port widths of the unit.
`timescale 1ns / 1ps

module fkin_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [263:0] in_tdata,
  input  logic         in_tuser,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [135:0] out_tdata,
  input  logic         out_tuser,
  input  logic         out_tlast,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic        kind;
    logic [5:0]  link_idx;
    logic [1:0]  row;
    logic [31:0] m0;
    logic [31:0] m1;
    logic [31:0] m2;
    logic [31:0] m3;
    logic        chain_end;
  } pose_word_t;

  localparam longint ATAN_Q[31] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
    5, 3, 1, 1};

  pose_word_t expected_words[$];
  longint     base_pose[12];
  longint     world_frame[12];
  longint     prev_axis_org[6];
  int         links_seen;
  bit         chain_open;

  assign pending = expected_words.size();

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic int sat_idx(input int v);
    return (v > 63) ? 63 : v;
  endfunction

  task automatic rotor(input logic [31:0] ang, output longint c, output longint s);
    logic [31:0] u;
    bit          flip;
    longint      x, y, z, dx, dy;
    u = ang;
    flip = 0;
    x = 652032874;
    y = 0;
    // Angles past a quarter turn are rotated by a half turn first.
    if (u > 32'h40000000 && u < 32'hC0000000) begin
      u = u + 32'h80000000;
      flip = 1;
    end
    z = longint'($signed(u));
    for (int i = 0; i < 31; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_Q[i];
      end else begin
        x += dx; y -= dy; z += ATAN_Q[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  task automatic push_centroid(input int idx, input longint a, input logic fin);
    pose_word_t w;
    longint     p[3];
    for (int j = 0; j < 3; j++)
      p[j] = clip32(prev_axis_org[3+j] + ((prev_axis_org[j] * a + (64'sd1 <<< 30)) >>> 31));
    w.kind = 1'b1;
    w.link_idx = idx[5:0];
    w.row = 2'd0;
    w.m0 = p[0][31:0];
    w.m1 = p[1][31:0];
    w.m2 = p[2][31:0];
    w.m3 = 32'd0;
    w.chain_end = fin;
    expected_words.push_back(w);
  endtask

  task automatic predict_link(input logic [263:0] d, input logic fin);
    longint     a, dz, ca, sa, ct, st, acc;
    longint     rel[12], nf[12];
    int         cur;
    pose_word_t w;
    a = longint'($signed(d[193:162]));
    dz = longint'($signed(d[225:194]));
    if (!chain_open) begin
      world_frame = base_pose;
      links_seen = 0;
    end
    rotor(d[161:130], ca, sa);
    rotor(d[257:226], ct, st);
    rel = '{ct, -st, 0, a,
            qmul(ca, st), qmul(ca, ct), -sa, qmul(-sa, dz),
            qmul(sa, st), qmul(sa, ct), ca, qmul(ca, dz)};
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++) begin
        acc = (c == 3) ? world_frame[r*4+3] : 0;
        for (int k = 0; k < 3; k++) acc += qmul(world_frame[r*4+k], rel[k*4+c]);
        nf[r*4+c] = clip32(acc);
      end
    cur = sat_idx(links_seen);
    if (chain_open) push_centroid(sat_idx(links_seen - 1), a, 1'b0);
    for (int r = 0; r < 3; r++) begin
      w.kind = 1'b0;
      w.link_idx = cur[5:0];
      w.row = r[1:0];
      w.m0 = nf[r*4][31:0];
      w.m1 = nf[r*4+1][31:0];
      w.m2 = nf[r*4+2][31:0];
      w.m3 = nf[r*4+3][31:0];
      w.chain_end = 1'b0;
      expected_words.push_back(w);
    end
    world_frame = nf;
    for (int r = 0; r < 3; r++) begin
      prev_axis_org[r] = nf[r*4];
      prev_axis_org[3+r] = nf[r*4+3];
    end
    if (links_seen < 64) links_seen++;
    chain_open = 1;
    if (fin) begin
      push_centroid(cur, a, 1'b1);
      chain_open = 0;
      links_seen = 0;
    end
  endtask

  always @(posedge clk) begin
    pose_word_t got, want;
    if (!rst_n) begin
      expected_words.delete();
      base_pose = '{1073741824, 0, 0, 0, 0, 1073741824, 0, 0, 0, 0, 1073741824, 0};
      world_frame = base_pose;
      prev_axis_org = '{0, 0, 0, 0, 0, 0};
      links_seen = 0;
      chain_open = 0;
      fail_count <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[5:0], out_tdata[7:6], out_tdata[39:8], out_tdata[71:40],
               out_tdata[103:72], out_tdata[135:104], out_tlast};
        if (expected_words.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch: expected kind %b link %0d row %0d m %h %h %h %h end %b,",
                       want.kind, want.link_idx, want.row, want.m0, want.m1, want.m2,
                       want.m3, want.chain_end,
                       " got kind %b link %0d row %0d m %h %h %h %h end %b",
                       got.kind, got.link_idx, got.row, got.m0, got.m1, got.m2,
                       got.m3, got.chain_end);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser) begin
          predict_link(in_tdata, in_tlast);
        end else if (in_tdata[1:0] != 2'd3) begin
          base_pose[in_tdata[1:0]*4+0] = longint'($signed(in_tdata[33:2]));
          base_pose[in_tdata[1:0]*4+1] = longint'($signed(in_tdata[65:34]));
          base_pose[in_tdata[1:0]*4+2] = longint'($signed(in_tdata[97:66]));
          base_pose[in_tdata[1:0]*4+3] = longint'($signed(in_tdata[129:98]));
        end
      end
    end
  end

endmodule

FILE: test/testbench.sv
// Top of the testbench for the serial chain forward kinematics unit: drives
// base-row and link words, stalls the result side, gives the verdict.
// Depends on fkin_pkg, the unit and fkin_checker.
`timescale 1ns / 1ps

module testbench;

  localparam logic OP_BASE = 1'b0;
  localparam logic OP_LINK = 1'b1;
  localparam int   CYCLE_LIMIT = 600000;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid, in_tready, in_tuser, in_tlast;
  logic [fkin_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                             out_tvalid, out_tready, out_tuser, out_tlast;
  logic [fkin_pkg::OUT_TDATA_W-1:0] out_tdata;
  int                               fail_count, pending;
  int                               words_sent;
  int                               cycles;

  serial_chain_forward_kinematics_unit dut (.*);

  fkin_checker chk (.*);

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // No idling on either side while this is true.
  function automatic bit calm();
    return words_sent >= 200 && words_sent < 260;
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(131072)) - 65536);
      2: return {2'($urandom_range(3)), 30'd0};
      3: return {1'($urandom_range(1)), {31{1'b1}}} ^ {31'd0, 1'($urandom_range(1))};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rot_entry();
    case ($urandom_range(3))
      0: return 32'($signed($urandom_range(32'h80000000)) - 32'sh40000000);
      1: return {2'($urandom_range(3)), 30'd0};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic op, input logic [fkin_pkg::IN_TDATA_W-1:0] d,
                           input logic fin);
    while (!calm() && $urandom_range(99) < 19) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= d;
    in_tlast <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_base(input logic [1:0] row, input logic [31:0] r0, r1, r2, t);
    send_word(OP_BASE, {6'd0, pick32(), pick32(), pick32(), pick32(), t, r2, r1, r0, row},
              1'($urandom_range(1)));
  endtask

  task automatic send_link(input logic [31:0] al, a, d, th, input logic fin);
    send_word(OP_LINK, {6'd0, th, d, a, al, pick32(), pick32(), pick32(), pick32(),
                        2'($urandom_range(3))}, fin);
  endtask

  task automatic random_base();
    send_base(2'($urandom_range(2)), rot_entry(), rot_entry(), rot_entry(), pick32());
  endtask

  // Result side: random stalls, plus one long hold-off once 150 words are sent.
  initial begin
    int  hold;
    bit  held;
    hold = 0;
    held = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && words_sent >= 150) begin
        held = 1;
        hold = 3000;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm() || $urandom_range(99) >= 19;
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin
    int n;
    words_sent = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser <= 1'b0;
    in_tlast <= 1'b0;
    in_tdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity base, angle extremes, length extremes, row three,
    // base load inside a chain, single-link chain.
    send_link(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    send_link(32'h40000000, 32'h7fffffff, 32'h80000000, 32'hC0000000, 1'b0);
    send_link(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b0);
    send_link(32'h40000001, 32'h00010000, 32'hffff0000, 32'hBFFFFFFF, 1'b1);
    send_base(2'd0, 32'h7fffffff, 32'h80000000, 32'h0, 32'h7fffffff);
    send_base(2'd1, 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h80000000);
    send_base(2'd2, 32'h0, 32'h40000000, 32'h7fffffff, 32'h00010000);
    send_base(2'd3, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_link(32'hffffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b0);
    send_base(2'd0, 32'h40000000, 32'h0, 32'h0, 32'h0);
    send_link(32'h20000000, 32'h80000000, 32'h80000000, 32'h60000000, 1'b0);
    send_link(32'hC0000000, 32'h12345678, 32'hedcba987, 32'h40000000, 1'b1);
    send_link(32'h55555555, 32'h00020000, 32'h00030000, 32'haaaaaaaa, 1'b1);
    send_base(2'd1, 32'h0, 32'h40000000, 32'h0, 32'h0);
    send_base(2'd2, 32'h0, 32'h0, 32'h40000000, 32'h0);

    // Random chains, one of them long enough to saturate the link index.
    while (words_sent < 360) begin
      if ($urandom_range(9) == 0) random_base();
      if ($urandom_range(19) == 0)
        send_base(2'd3, $urandom, $urandom, $urandom, $urandom);
      n = (words_sent > 60 && words_sent < 80) ? 70 : $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(29) == 0) random_base();
        send_link(pick32(), pick32(), pick32(), pick32(), i == n - 1);
      end
    end
    send_link($urandom, $urandom, $urandom, $urandom, 1'b0);
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/fkin_pkg.sv
src/fkin_cordic.sv
src/fkin_datapath.sv
src/fkin_ctrl.sv
src/serial_chain_forward_kinematics_unit.sv
test/fkin_checker.sv
test/testbench.sv
